[hw/rtl/fdtm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtm_pkg
// Shared constants and controller/datapath handshake types for the fan
// duty and tach monitor.
// ----------------------------------------------------------------------------
package fdtm_pkg;

	localparam int NUM_FANS   = 4;
	localparam int FAN_W      = 2;
	localparam int DUTY_W     = 8;
	localparam int TACH_W     = 8;
	localparam int ADDR_W     = 8;
	localparam int RPM_W      = 16;
	localparam int COUNT_W    = 13;

	// rpm = RPM_DIVIDEND / count, worked out one quotient bit per cycle
	localparam int unsigned RPM_DIVIDEND = 3932160 * 2;
	localparam int DIV_STEPS  = 23;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
	localparam int QUO_W      = DIV_STEPS;

	localparam logic [RPM_W-1:0]  RPM_MIN_VALID = RPM_W'(1000);
	localparam logic [RPM_W-1:0]  RPM_SAT       = '1;
	localparam logic [ADDR_W-1:0] DUTY_REG_BASE = 8'h30;
	localparam logic [ADDR_W-1:0] TACH_REG_BASE = 8'h3E;

	typedef enum logic {
		OP_SET_DUTY = 1'b0,
		OP_TACH     = 1'b1
	} op_t;

	typedef struct packed {
		logic load;      // capture the accepted item
		logic div_step;  // one restoring-division step
		logic commit;    // update stored duty/rpm
		logic out_load;  // fill the result register
	} dp_cmd_t;

	typedef struct packed {
		logic is_tach;
	} dp_status_t;

endpackage

[hw/rtl/fdtm_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtm_req_if
// Valid/ready channel carrying one set-duty or tach item.
// ----------------------------------------------------------------------------
interface fdtm_req_if;
	import fdtm_pkg::*;

	logic                valid;
	logic                ready;
	logic                op;
	logic [FAN_W-1:0]    fan;
	logic                all_fans;
	logic [DUTY_W-1:0]   duty;
	logic [TACH_W-1:0]   tach_high;
	logic [TACH_W-1:0]   tach_low;

	modport source (output valid, op, fan, all_fans, duty, tach_high, tach_low,
		input ready);
	modport sink (input valid, op, fan, all_fans, duty, tach_high, tach_low,
		output ready);
endinterface

[hw/rtl/fdtm_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtm_rsp_if
// Valid/ready channel carrying one result item with status flags.
// ----------------------------------------------------------------------------
interface fdtm_rsp_if;
	import fdtm_pkg::*;

	logic                valid;
	logic                ready;
	logic [DUTY_W-1:0]   applied_duty;
	logic [ADDR_W-1:0]   reg_address;
	logic [RPM_W-1:0]    rpm;
	logic                fans_enabled;
	logic                fan_error;
	logic                fans_ok;

	modport source (output valid, applied_duty, reg_address, rpm, fans_enabled,
		fan_error, fans_ok, input ready);
	modport sink (input valid, applied_duty, reg_address, rpm, fans_enabled,
		fan_error, fans_ok, output ready);
endinterface

[hw/rtl/fdtm_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtm_dp
// Datapath: duty clamp, restoring rpm divider, per-fan storage, status
// flags and the result register.
// ----------------------------------------------------------------------------
module fdtm_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fdtm_pkg::dp_cmd_t            cmd,
	output fdtm_pkg::dp_status_t         status,
	input  logic                         cfg_we,
	input  logic [fdtm_pkg::DUTY_W-1:0]  cfg_wdata,
	input  logic                         op,
	input  logic [fdtm_pkg::FAN_W-1:0]   fan,
	input  logic                         all_fans,
	input  logic [fdtm_pkg::DUTY_W-1:0]  duty,
	input  logic [fdtm_pkg::TACH_W-1:0]  tach_high,
	input  logic [fdtm_pkg::TACH_W-1:0]  tach_low,
	output logic [fdtm_pkg::DUTY_W-1:0]  applied_duty,
	output logic [fdtm_pkg::ADDR_W-1:0]  reg_address,
	output logic [fdtm_pkg::RPM_W-1:0]   rpm,
	output logic                         fans_enabled,
	output logic                         fan_error,
	output logic                         fans_ok
);
	import fdtm_pkg::*;

	logic [DUTY_W-1:0]  min_duty_q;
	logic               op_q;
	logic [FAN_W-1:0]   fan_q;
	logic               all_q;
	logic [DUTY_W-1:0]  applied_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] rem_q;
	logic [QUO_W-1:0]   quo_q;
	logic [RPM_W-1:0]   rpm_res_q;
	logic [DUTY_W-1:0]  duty_q [NUM_FANS];
	logic [RPM_W-1:0]   rpm_q  [NUM_FANS];

	logic [DUTY_W-1:0]  clamped;
	logic [COUNT_W:0]   trial;
	logic [COUNT_W:0]   diff;
	logic [RPM_W-1:0]   rpm_sat;
	logic [RPM_W-1:0]   rpm_fin;
	logic               any_en;
	logic               any_err;

	assign clamped = (duty != '0 && duty < min_duty_q) ? min_duty_q : duty;

	// shift next dividend bit into the partial remainder and try a subtract
	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign diff  = trial - {1'b0, count_q};

	always_comb begin
		rpm_sat = (quo_q[QUO_W-1:RPM_W] != '0) ? RPM_SAT : quo_q[RPM_W-1:0];
		if (count_q == '0 || rpm_sat < RPM_MIN_VALID) begin
			rpm_fin = '0;
		end else begin
			rpm_fin = rpm_sat;
		end
	end

	always_comb begin
		any_en  = 1'b0;
		any_err = 1'b0;
		for (int i = 0; i < NUM_FANS; i++) begin
			if (duty_q[i] != '0) begin
				any_en = 1'b1;
				if (rpm_q[i] == '0) begin
					any_err = 1'b1;
				end
			end
		end
	end

	assign status.is_tach = op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_duty_q <= '0;
		end else if (cfg_we) begin
			min_duty_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= op;
			fan_q     <= fan;
			all_q     <= all_fans;
			applied_q <= (op == OP_TACH) ? '0 : clamped;
			count_q   <= {tach_high, tach_low[TACH_W-1:3]};
			rem_q     <= '0;
			quo_q     <= QUO_W'(RPM_DIVIDEND);
		end else if (cmd.div_step) begin
			if (!diff[COUNT_W]) begin
				rem_q <= diff[COUNT_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[COUNT_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
		end
		if (cmd.commit) begin
			rpm_res_q <= op_q ? rpm_fin : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FANS; i++) begin
				duty_q[i] <= '0;
				rpm_q[i]  <= '0;
			end
		end else if (cmd.commit) begin
			for (int i = 0; i < NUM_FANS; i++) begin
				if (!op_q && (all_q || fan_q == FAN_W'(i))) begin
					duty_q[i] <= applied_q;
				end
				if (op_q && fan_q == FAN_W'(i)) begin
					rpm_q[i] <= rpm_fin;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			applied_duty <= applied_q;
			rpm          <= rpm_res_q;
			fans_enabled <= any_en;
			fan_error    <= any_err;
			fans_ok      <= !(any_en && any_err);
			if (op_q) begin
				reg_address <= ADDR_W'({fan_q, 4'h0}) + TACH_REG_BASE;
			end else if (all_q) begin
				reg_address <= DUTY_REG_BASE;
			end else begin
				reg_address <= ADDR_W'({fan_q, 4'h0}) + DUTY_REG_BASE;
			end
		end
	end

endmodule

[hw/rtl/fdtm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtm_ctrl
// Controller: sequences load, divider steps, storage update and result
// hand-off; owns both handshakes.
// ----------------------------------------------------------------------------
module fdtm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	input  fdtm_pkg::dp_status_t  status,
	output fdtm_pkg::dp_cmd_t     cmd
);
	import fdtm_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_COMMIT,
		S_OUT
	} state_t;

	state_t               state_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 rsp_valid_q;
	logic                 out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == S_IDLE) && req_valid;
		cmd.div_step = (state_q == S_DIV);
		cmd.commit   = (state_q == S_COMMIT);
		cmd.out_load = (state_q == S_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// a new result replaces one taken at this same edge
			if (state_q == S_OUT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						cnt_q   <= DIV_CNT_W'(DIV_STEPS - 1);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					// set-duty items skip the divider
					if (!status.is_tach || cnt_q == '0) begin
						state_q <= S_COMMIT;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_COMMIT: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/fan_duty_tach_monitor_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fan_duty_tach_monitor_top
// Four-fan duty and tach supervisor with minimum-duty clamp and status flags.
// ----------------------------------------------------------------------------
// One item at a time. A tach item is accepted, then its rpm is worked out as
// 7864320 / count by a restoring divider that produces one of 23 quotient
// bits per cycle, then it is stored and the result register is loaded.
// A set-duty item skips the divider. The result register is loaded once it
// is empty or its result is being taken, and the next item is accepted only
// after that. A new item is taken while the previous result still waits in
// the output register. min_duty may be written any time the block is idle
// and applies to later set-duty items.
module fan_duty_tach_monitor_top (
	input  logic                         clk,
	input  logic                         arst_n,
	fdtm_req_if.sink                     req,
	fdtm_rsp_if.source                   rsp,
	input  logic                         cfg_we,
	input  logic [fdtm_pkg::DUTY_W-1:0]  cfg_wdata
);
	import fdtm_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	fdtm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	fdtm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.op           (req.op),
		.fan          (req.fan),
		.all_fans     (req.all_fans),
		.duty         (req.duty),
		.tach_high    (req.tach_high),
		.tach_low     (req.tach_low),
		.applied_duty (rsp.applied_duty),
		.reg_address  (rsp.reg_address),
		.rpm          (rsp.rpm),
		.fans_enabled (rsp.fans_enabled),
		.fan_error    (rsp.fan_error),
		.fans_ok      (rsp.fans_ok)
	);

endmodule

[tb/sv/tb_fan_duty_tach_monitor_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fan_duty_tach_monitor_top
// Self-checking bench for the fan duty and tach monitor. Set-duty and tach
// items go in through bursty valid/ready traffic. Each result is checked
// against an in-bench model of the four fans (duty clamp, rpm division,
// status flags), while the result side stalls in shifting patterns.
// ----------------------------------------------------------------------------
module tb_fan_duty_tach_monitor_top;
	import fdtm_pkg::*;

	typedef struct packed {
		op_t                op;
		logic [FAN_W-1:0]   fan;
		logic               all_fans;
		logic [DUTY_W-1:0]  duty;
		logic [TACH_W-1:0]  tach_high;
		logic [TACH_W-1:0]  tach_low;
	} fan_cmd_t;

	typedef struct packed {
		logic [DUTY_W-1:0]  applied_duty;
		logic [ADDR_W-1:0]  reg_address;
		logic [RPM_W-1:0]   rpm;
		logic               fans_enabled;
		logic               fan_error;
		logic               fans_ok;
	} fan_report_t;

	localparam int RESULT_LATENCY = 32;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [DUTY_W-1:0]  cfg_wdata;

	fdtm_req_if req_ch ();
	fdtm_rsp_if rsp_ch ();

	fan_duty_tach_monitor_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// bench copy of the block state
	logic [DUTY_W-1:0]  min_duty_cfg;
	logic [DUTY_W-1:0]  duty_mem [NUM_FANS];
	logic [RPM_W-1:0]   rpm_mem [NUM_FANS];
	fan_report_t        fan_reports_due [$];
	int                 bad_fields;
	int                 burst_left;

	function automatic logic [RPM_W-1:0] rpm_from_tach(input logic [TACH_W-1:0] hi,
		input logic [TACH_W-1:0] lo);
		logic [COUNT_W-1:0] count;
		int unsigned        q;
		count = {hi, lo[7:3]};
		if (count == 0)
			return '0;
		q = RPM_DIVIDEND / count;
		if (q > RPM_SAT)
			q = RPM_SAT;
		if (q < RPM_MIN_VALID)
			q = 0;
		return q[RPM_W-1:0];
	endfunction

	// applies one item to the fan state and returns the result it must produce
	function automatic fan_report_t update_fans(input fan_cmd_t c);
		fan_report_t r;
		logic        enabled;
		logic        err;
		int          i;
		r = '0;
		if (c.op == OP_SET_DUTY) begin
			r.applied_duty = (c.duty != 0 && c.duty < min_duty_cfg) ? min_duty_cfg : c.duty;
			if (c.all_fans) begin
				for (i = 0; i < NUM_FANS; i++)
					duty_mem[i] = r.applied_duty;
				r.reg_address = DUTY_REG_BASE;
			end else begin
				duty_mem[c.fan] = r.applied_duty;
				r.reg_address = {2'b00, c.fan, 4'b0000} + DUTY_REG_BASE;
			end
		end else begin
			r.rpm = rpm_from_tach(c.tach_high, c.tach_low);
			rpm_mem[c.fan] = r.rpm;
			r.reg_address = {2'b00, c.fan, 4'b0000} + TACH_REG_BASE;
		end
		enabled = 1'b0;
		err = 1'b0;
		for (i = 0; i < NUM_FANS; i++) begin
			if (duty_mem[i] != 0) begin
				enabled = 1'b1;
				if (rpm_mem[i] == 0)
					err = 1'b1;
			end
		end
		r.fans_enabled = enabled;
		r.fan_error = err;
		r.fans_ok = !(enabled && err);
		return r;
	endfunction

	function automatic fan_cmd_t duty_cmd(input logic [FAN_W-1:0] fan, input logic all,
		input logic [DUTY_W-1:0] duty);
		fan_cmd_t c;
		c = '0;
		c.op = OP_SET_DUTY;
		c.fan = fan;
		c.all_fans = all;
		c.duty = duty;
		c.tach_high = $urandom;
		c.tach_low = $urandom;
		return c;
	endfunction

	// junk fills tach_low[2:0], which the count ignores
	function automatic fan_cmd_t tach_cmd(input logic [FAN_W-1:0] fan,
		input logic [COUNT_W-1:0] count, input logic [2:0] junk);
		fan_cmd_t c;
		c = '0;
		c.op = OP_TACH;
		c.fan = fan;
		c.all_fans = $urandom_range(0, 1);
		c.duty = $urandom;
		c.tach_high = count[12:5];
		c.tach_low = {count[4:0], junk};
		return c;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		bad_fields++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
		input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
	endtask

	// sender: bursts of items separated by random gaps
	task automatic send_item(input fan_cmd_t c);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		req_ch.valid     <= 1'b1;
		req_ch.op        <= c.op;
		req_ch.fan       <= c.fan;
		req_ch.all_fans  <= c.all_fans;
		req_ch.duty      <= c.duty;
		req_ch.tach_high <= c.tach_high;
		req_ch.tach_low  <= c.tach_low;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		fan_reports_due.push_back(update_fans(c));
		burst_left--;
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (fan_reports_due.size() != 0)
			@(posedge clk);
		repeat (RESULT_LATENCY) @(posedge clk);
	endtask

	task automatic write_min_duty(input logic [DUTY_W-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		min_duty_cfg = value;
	endtask

	// result side: stall pattern is redrawn whenever its random hold count runs out
	int stall_mode;
	int stall_left;
	int stall_phase;

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(50, 300);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: rsp_ch.ready <= 1'b1;
			1: rsp_ch.ready <= $urandom_range(0, 1);
			2: rsp_ch.ready <= (stall_phase % 5 == 0);
			default: rsp_ch.ready <= ($urandom_range(0, 31) == 0);
		endcase
		stall_phase++;
	end

	always @(posedge clk) begin
		fan_report_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (fan_reports_due.size() == 0) begin
				report_mismatch("result with no item outstanding");
			end else begin
				want = fan_reports_due.pop_front();
				check_field("applied_duty", rsp_ch.applied_duty, want.applied_duty);
				check_field("reg_address", rsp_ch.reg_address, want.reg_address);
				check_field("rpm", rsp_ch.rpm, want.rpm);
				check_field("fans_enabled", rsp_ch.fans_enabled, want.fans_enabled);
				check_field("fan_error", rsp_ch.fan_error, want.fan_error);
				check_field("fans_ok", rsp_ch.fans_ok, want.fans_ok);
			end
		end
	end

	task automatic test_duty_directed();
		send_item(duty_cmd(2'd0, 1'b0, 8'd0));
		send_item(duty_cmd(2'd3, 1'b0, 8'd255));
		// broadcast reports the first duty register whatever fan says
		send_item(duty_cmd(2'd2, 1'b1, 8'd1));
		send_item(duty_cmd(2'd1, 1'b0, 8'd0));
	endtask

	task automatic test_tach_directed();
		send_item(tach_cmd(2'd0, 13'd0, 3'd7));       // zero count
		send_item(tach_cmd(2'd1, 13'd1, 3'd0));       // saturates
		send_item(tach_cmd(2'd2, 13'd120, 3'd5));     // exactly 65536, saturates
		send_item(tach_cmd(2'd3, 13'd121, 3'd2));     // largest unsaturated
		send_item(tach_cmd(2'd0, 13'd7864, 3'd1));    // 1000, still valid
		send_item(tach_cmd(2'd1, 13'd7865, 3'd6));    // just under 1000, slow fan
		send_item(tach_cmd(2'd2, 13'h1FFF, 3'd7));    // both bytes all ones
		send_item(tach_cmd(2'd3, 13'd4096, 3'd3));
		send_item(duty_cmd(2'd0, 1'b1, 8'd0));
	endtask

	task automatic test_min_duty_clamp();
		write_min_duty(8'd255);
		send_item(duty_cmd(2'd1, 1'b0, 8'd1));
		send_item(duty_cmd(2'd2, 1'b0, 8'd0));
		send_item(duty_cmd(2'd3, 1'b1, 8'd254));
		write_min_duty(8'd128);
		send_item(duty_cmd(2'd0, 1'b0, 8'd127));
		send_item(duty_cmd(2'd1, 1'b0, 8'd128));
		send_item(duty_cmd(2'd2, 1'b0, 8'd129));
	endtask

	task automatic test_random_traffic();
		logic [DUTY_W-1:0]  minimums [6];
		logic [DUTY_W-1:0]  d;
		logic [COUNT_W-1:0] cnt;
		int                 p;
		int                 n;
		minimums = '{8'd0, 8'd255, 8'd1, 8'd100, 8'd0, 8'd0};
		minimums[4] = $urandom;
		minimums[5] = $urandom;
		for (p = 0; p < 6; p++) begin
			write_min_duty(minimums[p]);
			for (n = 0; n < 290; n++) begin
				if ($urandom_range(0, 1) == 0) begin
					case ($urandom_range(0, 5))
						0: d = 8'd0;
						1: d = min_duty_cfg + $urandom_range(0, 4) - 2;
						2: d = 8'd255;
						default: d = $urandom;
					endcase
					send_item(duty_cmd($urandom, $urandom_range(0, 5) == 0, d));
				end else begin
					case ($urandom_range(0, 9))
						0: cnt = '0;
						1: cnt = $urandom_range(1, 121);
						2: cnt = $urandom_range(7800, 7930);
						3: cnt = $urandom_range(7865, 8191);
						4: cnt = $urandom;
						default: cnt = $urandom_range(122, 7864);
					endcase
					send_item(tach_cmd($urandom, cnt, $urandom));
				end
			end
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		req_ch.valid     = 1'b0;
		req_ch.op        = 1'b0;
		req_ch.fan       = '0;
		req_ch.all_fans  = 1'b0;
		req_ch.duty      = '0;
		req_ch.tach_high = '0;
		req_ch.tach_low  = '0;
		rsp_ch.ready     = 1'b0;
		min_duty_cfg     = '0;
		for (int i = 0; i < NUM_FANS; i++) begin
			duty_mem[i] = '0;
			rpm_mem[i]  = '0;
		end
		bad_fields  = 0;
		burst_left  = 0;
		stall_mode  = 0;
		stall_left  = 0;
		stall_phase = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_duty_directed();
		test_tach_directed();
		test_min_duty_clamp();
		test_random_traffic();
		wait_idle();

		if (bad_fields == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#12_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/fdtm_pkg.sv
hw/rtl/fdtm_req_if.sv
hw/rtl/fdtm_rsp_if.sv
hw/rtl/fdtm_dp.sv
hw/rtl/fdtm_ctrl.sv
hw/rtl/fan_duty_tach_monitor_top.sv
tb/sv/tb_fan_duty_tach_monitor_top.sv
